// ===== sv/bcomp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcomp_pkg
// Shared types and constants of the barometer compensation block.
// ----------------------------------------------------------------------------
package bcomp_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MC_MD   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OSS     = 3'd5;

  localparam logic        OP_TEMP  = 1'b0;
  localparam logic        OP_PRESS = 1'b1;

  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] B4_OFFSET   = 32'd32768;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] B7_LIMIT    = 32'h8000_0000;
  localparam logic [31:0] P_COEF_SQ   = 32'd3038;
  localparam logic [31:0] P_COEF_LIN  = 32'hFFFF_E343; // -7357
  localparam logic [31:0] P_COEF_OFS  = 32'd3791;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/baro_temp_pressure_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation for a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Write the five calibration words and the oversampling setting through
//   cfg_wr_en / cfg_index / cfg_data while the block is idle.
//   Present a request on in_valid/in_ready: operation 0 is a raw temperature
//   (bits 15..0), operation 1 a raw 24-bit pressure. A temperature request
//   without a divide fault stores B5, which later pressure requests use (B5 is 0 after reset).
//   Each request yields one result on out_valid/out_ready.
// Sequencing:
//   One request at a time. Each request passes through the bit-serial divider
//   and a chain of products through one shared registered multiplier, a
//   pressure request through a longer chain; a zero divisor skips the divider.
//   in_ready is high while the sequencer is idle, also while a result waits.
// Stall:
//   A finished result holds in the sequencer until the output register is
//   free; the output register holds until out_ready takes it.
// Reset:
//   rst (synchronous) clears the configuration, the state, B5 and out_valid.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation import bcomp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [23:0]        raw_reading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_kind,
  output logic signed [31:0] compensated_value,
  output logic               divide_fault
);

  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_T1, S_T2,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_P11,
    S_P12, S_FIN
  } state_t;

  // configuration registers
  logic [31:0] ac1_ac2, ac3_ac4, ac5_ac6, b1_b2, mc_md;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      ac1_ac2 <= '0;
      ac3_ac4 <= '0;
      ac5_ac6 <= '0;
      b1_b2   <= '0;
      mc_md   <= '0;
      oss     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_AC1_AC2: ac1_ac2 <= cfg_data;
        REG_AC3_AC4: ac3_ac4 <= cfg_data;
        REG_AC5_AC6: ac5_ac6 <= cfg_data;
        REG_B1_B2:   b1_b2   <= cfg_data;
        REG_MC_MD:   mc_md   <= cfg_data;
        REG_OSS:     oss     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sign-extended calibration fields (AC4, AC5 and AC6 zero-extended)
  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [31:0] ac4, ac5, ac6;
  assign ac1 = {{16{ac1_ac2[31]}}, ac1_ac2[31:16]};
  assign ac2 = {{16{ac1_ac2[15]}}, ac1_ac2[15:0]};
  assign ac3 = {{16{ac3_ac4[31]}}, ac3_ac4[31:16]};
  assign ac4 = {16'd0, ac3_ac4[15:0]};
  assign ac5 = {16'd0, ac5_ac6[31:16]};
  assign ac6 = {16'd0, ac5_ac6[15:0]};
  assign b1  = {{16{b1_b2[31]}}, b1_b2[31:16]};
  assign b2  = {{16{b1_b2[15]}}, b1_b2[15:0]};
  assign mc  = {{16{mc_md[31]}}, mc_md[31:16]};
  assign md  = {{16{mc_md[15]}}, mc_md[15:0]};

  state_t             state;
  logic [23:0]        raw;
  logic signed [31:0] b5;
  logic signed [31:0] x1, sq, acc, b3, p;
  logic        [31:0] b4, b7;
  logic               neg;
  logic               res_kind;
  logic signed [31:0] res_value;
  logic               res_fault;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  div_req_t    dreq;
  div_rsp_t    drsp;

  bcomp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));
  bcomp_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // datapath helpers
  logic signed [31:0] plo, b6, num, x1_n, den_n, q_s, x3_n, b3_n, x3b_n, p_n;
  logic        [31:0] up, t_p, den_abs, num_abs;
  assign plo   = prod[31:0];
  assign b6    = b5 - $signed(B6_OFFSET);
  assign num   = {mc[20:0], 11'd0};
  assign x1_n  = plo >>> 15;
  assign den_n = x1_n + md;
  assign num_abs = num[31] ? -num : num;
  assign den_abs = den_n[31] ? -den_n : den_n;
  assign q_s   = neg ? -$signed(drsp.quotient) : $signed(drsp.quotient);
  assign x3_n  = acc + (plo >>> 11);
  assign b3_n  = ((($signed({ac1[29:0], 2'b00}) + x3_n) << oss) + 32'sd2) >>> 2;
  assign x3b_n = (acc + (plo >>> 16) + 32'sd2) >>> 2;
  assign up    = {8'd0, raw} >> (4'd8 - {2'd0, oss});
  assign p_n   = (b7 < B7_LIMIT) ? drsp.quotient : {drsp.quotient[30:0], 1'b0};
  assign t_p   = p >>> 8;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_T0:  begin mul_a = {16'd0, raw[15:0]} - ac6; mul_b = ac5; end
      S_P0:  begin mul_a = b6;  mul_b = b6; end
      S_P1:  begin mul_a = b2;  mul_b = plo >>> 12; end
      S_P2:  begin mul_a = ac2; mul_b = b6; end
      S_P3:  begin mul_a = ac3; mul_b = b6; end
      S_P4:  begin mul_a = b1;  mul_b = sq; end
      S_P5:  begin mul_a = ac4; mul_b = x3b_n + B4_OFFSET; end
      S_P6:  begin mul_a = up - b3; mul_b = B7_SCALE >> oss; end
      S_P9:  begin mul_a = t_p; mul_b = t_p; end
      S_P10: begin mul_a = plo; mul_b = P_COEF_SQ; end
      S_P11: begin mul_a = P_COEF_LIN; mul_b = p; end
      default: ;
    endcase
  end

  always_comb begin
    dreq = '0;
    if (state == S_T1 && den_n != 0) begin
      dreq.start    = 1'b1;
      dreq.dividend = num_abs;
      dreq.divisor  = den_abs;
    end else if (state == S_P7 && b4 != 0) begin
      dreq.start    = 1'b1;
      dreq.dividend = (plo < B7_LIMIT) ? {plo[30:0], 1'b0} : plo;
      dreq.divisor  = b4;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      b5        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw       <= raw_reading;
            res_kind  <= operation;
            res_fault <= 1'b0;
            res_value <= '0;
            state     <= (operation == OP_PRESS) ? S_P0 : S_T0;
          end
        end
        S_T0: state <= S_T1;
        S_T1: begin
          x1  <= x1_n;
          neg <= num[31] ^ den_n[31];
          if (den_n == 0) begin
            res_fault <= 1'b1;
            state     <= S_FIN;
          end else begin
            state <= S_T2;
          end
        end
        S_T2: begin
          if (drsp.done) begin
            b5        <= x1 + q_s;
            res_value <= (x1 + q_s + 32'sd8) >>> 4;
            state     <= S_FIN;
          end
        end
        S_P0: state <= S_P1;
        S_P1: begin sq  <= plo >>> 12; state <= S_P2; end
        S_P2: begin acc <= plo >>> 11; state <= S_P3; end
        S_P3: begin b3  <= b3_n;       state <= S_P4; end
        S_P4: begin acc <= plo >>> 13; state <= S_P5; end
        S_P5: state <= S_P6;
        S_P6: begin b4  <= prod[46:15]; state <= S_P7; end
        S_P7: begin
          b7 <= plo;
          if (b4 == 0) begin
            res_fault <= 1'b1;
            state     <= S_FIN;
          end else begin
            state <= S_P8;
          end
        end
        S_P8: begin
          if (drsp.done) begin
            p     <= p_n;
            state <= S_P9;
          end
        end
        S_P9:  state <= S_P10;
        S_P10: state <= S_P11;
        S_P11: begin acc <= plo >>> 16; state <= S_P12; end
        S_P12: begin
          res_value <= p + ((acc + (plo >>> 16) + $signed(P_COEF_OFS)) >>> 4);
          state     <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            result_kind       <= res_kind;
            compensated_value <= res_value;
            divide_fault      <= res_fault;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bcomp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcomp_div
// Unsigned 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcomp_div import bcomp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        // shift in one dividend bit, subtract where it fits
        if (!diff[32]) begin
          rem <= diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

  assign rsp.quotient = quo;

endmodule

// ===== sv/bcomp_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcomp_mul
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module bcomp_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= {32'd0, a} * {32'd0, b};
  end

endmodule
